### rtl/mctt_pkg.sv
// Package: types, sizes and command codes of the multi-channel timer table.
package mctt_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int TIME_BITS    = 48;
  localparam int PERIOD_BITS  = 32;

  localparam int IDX_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_BITS  = $clog2(NUM_CHANNELS + 1);
  localparam int STEP_BITS = $clog2(TIME_BITS - 1);

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  channel;
    logic [31:0] timeout_ms;
    logic        repeat_req;
    logic [15:0] elapsed_ms;
  } cmd_item_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_channel;
    logic        any_armed;
    logic [47:0] earliest_deadline;
    logic        last;
  } res_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   deadline;
    logic [PERIOD_BITS-1:0] period;
    logic                   periodic;
  } chan_entry_t;

endpackage

### rtl/multi_channel_timer_table.sv
// Top level: timer channel table with tick scan, catch-up remainder unit and result register.
//
// Multi-channel timer table. Each channel holds a deadline, a period and a
// one-shot/periodic flag in a single-port-read channel memory; armed bits sit
// in flip-flops so that reset clears them at once and no clearing pass is
// needed. Start and stop are done directly from idle. A tick advances the
// millisecond counter, then walks the channels in index order: an idle channel
// is skipped at the issue step, an armed one is read from memory and then
// evaluated. A due periodic channel with a nonzero period also goes through
// the remainder unit, which works out (now - deadline) mod period one bit per
// cycle over the TIME_BITS-1 low bits of the lag, then a write-back step;
// the new deadline is now plus the distance to the next period boundary.
// A stall on the result side holds the scan. Fire transfers come out in
// channel order, and every tick closes with a summary transfer carrying
// last, the armed flag and the earliest remaining deadline (smallest
// distance ahead of now, lowest channel on a tie). Time and deadlines wrap
// modulo 2^TIME_BITS. New commands are taken only between ticks; a finished
// result may still wait in the output register while the next command is
// accepted.
module multi_channel_timer_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  mctt_pkg::cmd_item_t cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output mctt_pkg::res_item_t res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;

  localparam int TB = mctt_pkg::TIME_BITS;
  localparam int PB = mctt_pkg::PERIOD_BITS;

  logic [2:0] state;

  // Time counter and per-channel armed flags.
  logic [TB-1:0]                     now_ms;
  logic [mctt_pkg::NUM_CHANNELS-1:0] armed;

  // Channel memory: one write port, one registered read port.
  mctt_pkg::chan_entry_t mem [mctt_pkg::NUM_CHANNELS];
  mctt_pkg::chan_entry_t rd_q;
  logic                          mem_we;
  logic                          mem_re;
  logic [mctt_pkg::IDX_BITS-1:0] mem_wa;
  mctt_pkg::chan_entry_t         mem_wd;

  // Scan position.
  logic [mctt_pkg::CNT_BITS-1:0] idx;
  logic [mctt_pkg::IDX_BITS-1:0] idx_a;
  logic                          scan_done;

  // Remainder unit.
  logic [TB-2:0]                  behind;
  logic [PB-1:0]                  rem;
  logic [PB:0]                    rem_sh;
  logic [PB-1:0]                  rem_next;
  logic [mctt_pkg::STEP_BITS-1:0] step;
  logic [PB-1:0]                  fill;

  // Running minimum for the summary.
  logic          any;
  logic [TB-1:0] best_dist;
  logic [TB-1:0] best_dl;
  logic          fold_en;
  logic [TB-1:0] fold_dl;
  logic [TB-1:0] fold_dist;

  logic          cmd_accept;
  logic          ch_ok;
  logic          out_free;
  logic [TB-1:0] diff;
  logic          due;
  logic [TB-1:0] start_dl;
  logic [TB-1:0] new_dl;
  logic [63:0]   best_wide;

  logic                res_load;
  mctt_pkg::res_item_t res_next;

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign ch_ok      = (32'(cmd.channel) < mctt_pkg::NUM_CHANNELS);
  assign out_free   = !res_valid || !res_stall;

  assign idx_a     = idx[mctt_pkg::IDX_BITS-1:0];
  assign scan_done = (idx == mctt_pkg::CNT_BITS'(mctt_pkg::NUM_CHANNELS));

  // A deadline is due when it lies strictly behind now within half the range.
  assign diff = now_ms - rd_q.deadline;
  assign due  = (diff != '0) && !diff[TB-1];

  assign start_dl = now_ms + TB'(cmd.timeout_ms);

  // Restoring remainder step: shift in the next bit of the lag, subtract if it fits.
  assign rem_sh   = {rem, behind[TB-2]};
  assign rem_next = (rem_sh >= {1'b0, rd_q.period}) ? PB'(rem_sh - {1'b0, rd_q.period})
                                                    : rem_sh[PB-1:0];

  // Distance to the next period boundary, zero when the lag is a whole number of periods.
  assign fill   = (rem != '0) ? (rd_q.period - rem) : '0;
  assign new_dl = now_ms + TB'(fill);

  assign fold_dist = fold_dl - now_ms;
  assign best_wide = 64'(best_dl);

  assign mem_re = (state == S_ISSUE) && !scan_done && armed[idx_a];

  // Write port and summary fold.
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = mctt_pkg::IDX_BITS'(cmd.channel);
    mem_wd  = '{deadline: start_dl, period: cmd.timeout_ms, periodic: cmd.repeat_req};
    fold_en = 1'b0;
    fold_dl = rd_q.deadline;
    case (state)
      S_IDLE: begin
        if (cmd_accept && (cmd.command == mctt_pkg::CMD_START) && ch_ok) begin
          mem_we = 1'b1;
        end
      end
      S_EVAL: begin
        if (!due) begin
          fold_en = 1'b1;
        end else if (out_free && rd_q.periodic && (rd_q.period == '0)) begin
          mem_we  = 1'b1;
          mem_wa  = idx_a;
          mem_wd  = '{deadline: now_ms, period: rd_q.period, periodic: rd_q.periodic};
          fold_en = 1'b1;
          fold_dl = now_ms;
        end
      end
      S_WB: begin
        mem_we  = 1'b1;
        mem_wa  = idx_a;
        mem_wd  = '{deadline: new_dl, period: rd_q.period, periodic: rd_q.periodic};
        fold_en = 1'b1;
        fold_dl = new_dl;
      end
      default: begin
      end
    endcase
  end

  // Result register load: fire transfers during the scan, summary at the end.
  always_comb begin
    res_load = 1'b0;
    res_next = '{fired: 1'b1, fired_channel: 4'(idx_a), any_armed: 1'b0,
                 earliest_deadline: '0, last: 1'b0};
    case (state)
      S_EVAL: begin
        res_load = due && out_free;
      end
      S_SUM: begin
        res_load = out_free;
        res_next = '{fired: 1'b0, fired_channel: '0, any_armed: any,
                     earliest_deadline: any ? best_wide[47:0] : 48'd0, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Channel memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[idx_a];
    end
  end

  // Output register: hold until taken, reload as soon as the slot frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  // Summary minimum; strict compare keeps the lowest channel on a tie.
  always_ff @(posedge clk) begin
    if (rst) begin
      any <= 1'b0;
    end else if (state == S_IDLE) begin
      any <= 1'b0;
    end else if (fold_en && (!any || (fold_dist < best_dist))) begin
      any <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fold_en && (!any || (fold_dist < best_dist))) begin
      best_dist <= fold_dist;
      best_dl   <= fold_dl;
    end
  end

  // Remainder unit datapath.
  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      behind <= diff[TB-2:0];
      rem    <= '0;
      step   <= '0;
    end else if (state == S_DIV) begin
      behind <= behind << 1;
      rem    <= rem_next;
      step   <= step + 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      now_ms <= '0;
      armed  <= '0;
      idx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            case (cmd.command)
              mctt_pkg::CMD_START: begin
                if (ch_ok) begin
                  armed[mctt_pkg::IDX_BITS'(cmd.channel)] <= 1'b1;
                end
              end
              mctt_pkg::CMD_STOP: begin
                if (ch_ok) begin
                  armed[mctt_pkg::IDX_BITS'(cmd.channel)] <= 1'b0;
                end
              end
              mctt_pkg::CMD_TICK: begin
                now_ms <= now_ms + TB'(cmd.elapsed_ms);
                idx    <= '0;
                state  <= S_ISSUE;
              end
              default: begin
              end
            endcase
          end
        end
        S_ISSUE: begin
          if (scan_done) begin
            state <= S_SUM;
          end else if (armed[idx_a]) begin
            state <= S_EVAL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EVAL: begin
          if (!due) begin
            idx   <= idx + 1'b1;
            state <= S_ISSUE;
          end else if (out_free) begin
            if (!rd_q.periodic) begin
              armed[idx_a] <= 1'b0;
              idx          <= idx + 1'b1;
              state        <= S_ISSUE;
            end else if (rd_q.period == '0) begin
              idx   <= idx + 1'b1;
              state <= S_ISSUE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (step == mctt_pkg::STEP_BITS'(TB - 2)) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          idx   <= idx + 1'b1;
          state <= S_ISSUE;
        end
        S_SUM: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The remainder never reaches the period while it is being worked out.
  a_rem_below_period: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < rd_q.period))
    else $error("remainder reached the period");

  // Only armed channels are evaluated.
  a_eval_armed: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> armed[idx_a])
    else $error("evaluating a disarmed channel");

  // A fire transfer never closes a run, a summary always does.
  a_fire_last: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.fired != res.last))
    else $error("fired and last disagree");

  // A summary transfer is loaded only on the way back to idle.
  a_sum_idle: assert property (@(posedge clk) disable iff (rst)
    (res_load && (state == S_SUM)) |=> (state == S_IDLE))
    else $error("summary loaded without ending the tick");
`endif

endmodule
